/* rtl/integer_to_ascii_formatter_macros.svh */
// Assertion wrappers for the formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
`define ITOA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("itoa_fmt: assertion failed");
`define ITOA_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("itoa_fmt: sequence check failed");
`else
`define ITOA_ASSERT(name, clk, rst, prop)
`define ITOA_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

/* rtl/itoa_fmt_pkg.sv */
package itoa_fmt_pkg;

  localparam int MAX_FIELD = 60;
  localparam int FLD_W     = 6;
  localparam int IN_W      = 56;
  localparam int NDIG      = 11;
  localparam int ND_W      = 4;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_PADL = 3'd0;
  localparam logic [PH_W-1:0] PH_LEAD = 3'd1;
  localparam logic [PH_W-1:0] PH_ZERO = 3'd2;
  localparam logic [PH_W-1:0] PH_DIG  = 3'd3;
  localparam logic [PH_W-1:0] PH_PADR = 3'd4;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_A_UP  = 8'h41;
  localparam logic [7:0] ASCII_A_LO  = 8'h61;
  localparam logic [7:0] ASCII_X_UP  = 8'h58;
  localparam logic [7:0] ASCII_X_LO  = 8'h78;

  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  typedef struct packed {
    logic            load;
    logic            step;
    logic            calc;
    logic            ph_load;
    logic            emit;
    logic [PH_W-1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic empty;
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] base_ch;
    base_ch = lower ? ASCII_A_LO : ASCII_A_UP;
    if (d < 4'd10) begin
      digit_char = ASCII_0 + {4'b0, d};
    end else begin
      digit_char = base_ch + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

/* rtl/itoa_fmt_ctrl.sv */
module itoa_fmt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  itoa_fmt_pkg::stat_t  st,
  output itoa_fmt_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_NEXT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state, state_next;
  logic [itoa_fmt_pkg::PH_W-1:0] ph, ph_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= itoa_fmt_pkg::PH_PADL;
    end else begin
      state <= state_next;
      ph    <= ph_next;
    end
  end

  always_comb begin
    state_next  = state;
    ph_next     = ph;
    cmd         = '0;
    cmd.phase   = ph;
    s_tready    = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (st.div_last) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        ph_next  = itoa_fmt_pkg::PH_PADL;
        state_next = st.empty ? S_IDLE : S_NEXT;
      end
      S_NEXT: begin
        cmd.ph_load = 1'b1;
        if (!st.cnt_zero) begin
          state_next = S_EMIT;
        end else if (ph == itoa_fmt_pkg::PH_PADR) begin
          state_next = S_IDLE;
        end else begin
          ph_next = ph + 3'd1;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.cnt_one) begin
            if (ph == itoa_fmt_pkg::PH_PADR) begin
              state_next = S_IDLE;
            end else begin
              ph_next    = ph + 3'd1;
              state_next = S_NEXT;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/itoa_fmt_dp.sv */
`include "integer_to_ascii_formatter_macros.svh"

module itoa_fmt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [itoa_fmt_pkg::IN_W-1:0] s_tdata,
  input  itoa_fmt_pkg::cmd_t            cmd,
  output itoa_fmt_pkg::stat_t           st,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,
  output logic                          m_tlast
);

  // input fields
  logic [31:0] in_value;
  logic [1:0]  in_base;
  logic        in_signed, in_lower, in_plus, in_space, in_prefix, in_zpad, in_ljust;
  logic [5:0]  in_width;
  logic [6:0]  in_prec;

  assign in_value  = s_tdata[31:0];
  assign in_base   = s_tdata[33:32];
  assign in_signed = s_tdata[34];
  assign in_lower  = s_tdata[35];
  assign in_plus   = s_tdata[36];
  assign in_space  = s_tdata[37];
  assign in_prefix = s_tdata[38];
  assign in_zpad   = s_tdata[39];
  assign in_ljust  = s_tdata[40];
  assign in_width  = s_tdata[46:41];
  assign in_prec   = s_tdata[53:47];

  logic [31:0] mag;
  logic [1:0]  base;
  logic        vzero, lower, pfx, zpad, ljust, p_abs;
  logic [itoa_fmt_pkg::FLD_W-1:0] w_sat, p_val, zeros, padn, cnt;
  logic [1:0]  nl;
  logic [7:0]  lead0, lead1;
  logic [3:0]  dig [itoa_fmt_pkg::NDIG];
  logic [itoa_fmt_pkg::ND_W-1:0] nd;

  // load decode
  logic        ld_dec, ld_hex, ld_neg, ld_vzero;
  logic [1:0]  ld_base;

  always_comb begin
    ld_dec   = (in_base == itoa_fmt_pkg::BASE_DEC);
    ld_hex   = !ld_dec && (in_base != itoa_fmt_pkg::BASE_OCT);
    ld_base  = ld_dec ? itoa_fmt_pkg::BASE_DEC :
               (ld_hex ? itoa_fmt_pkg::BASE_HEX : itoa_fmt_pkg::BASE_OCT);
    ld_neg   = ld_dec && in_signed && in_value[31];
    ld_vzero = (in_value == 32'd0);
  end

  // one digit per cycle
  logic [63:0] prod;
  logic [31:0] q, q10;
  logic [3:0]  r;

  always_comb begin
    prod = 64'(mag) * 64'(itoa_fmt_pkg::RECIP10);
    q10  = 32'(prod[63:35]);
    case (base)
      itoa_fmt_pkg::BASE_DEC: begin
        q = q10;
        r = 4'(mag - {q10[28:0], 3'b0} - {q10[30:0], 1'b0});
      end
      itoa_fmt_pkg::BASE_OCT: begin
        q = {3'b0, mag[31:3]};
        r = {1'b0, mag[2:0]};
      end
      default: begin
        q = {4'b0, mag[31:4]};
        r = mag[3:0];
      end
    endcase
  end

  // field layout
  logic [itoa_fmt_pkg::FLD_W-1:0] zeros0, padn0, ph_cnt, nd_ext;
  logic [6:0] body;

  always_comb begin
    nd_ext = itoa_fmt_pkg::FLD_W'(nd);
    if (!p_abs && p_val > nd_ext) begin
      zeros0 = p_val - nd_ext;
    end else begin
      zeros0 = '0;
    end
    if (pfx && !vzero && base == itoa_fmt_pkg::BASE_OCT && zeros0 == '0) begin
      zeros0 = itoa_fmt_pkg::FLD_W'(1);
    end
    body  = 7'(nl) + 7'(zeros0) + 7'(nd);
    padn0 = (7'(w_sat) > body) ? itoa_fmt_pkg::FLD_W'(7'(w_sat) - body) : '0;
    case (cmd.phase)
      itoa_fmt_pkg::PH_PADL: ph_cnt = ljust ? '0 : padn;
      itoa_fmt_pkg::PH_LEAD: ph_cnt = itoa_fmt_pkg::FLD_W'(nl);
      itoa_fmt_pkg::PH_ZERO: ph_cnt = zeros;
      itoa_fmt_pkg::PH_DIG:  ph_cnt = nd_ext;
      itoa_fmt_pkg::PH_PADR: ph_cnt = ljust ? padn : '0;
      default:               ph_cnt = '0;
    endcase
  end

  // character select
  logic [7:0] ch_sel;
  logic       last_sel;
  logic [itoa_fmt_pkg::ND_W-1:0] didx;

  always_comb begin
    didx = itoa_fmt_pkg::ND_W'(cnt - itoa_fmt_pkg::FLD_W'(1));
    case (cmd.phase)
      itoa_fmt_pkg::PH_LEAD: ch_sel = (cnt == itoa_fmt_pkg::FLD_W'(nl)) ? lead0 : lead1;
      itoa_fmt_pkg::PH_ZERO: ch_sel = itoa_fmt_pkg::ASCII_0;
      itoa_fmt_pkg::PH_DIG:  ch_sel = itoa_fmt_pkg::digit_char(dig[didx], lower);
      default:               ch_sel = itoa_fmt_pkg::ASCII_SPACE;
    endcase
    last_sel = st.cnt_one &&
               ((cmd.phase == itoa_fmt_pkg::PH_PADR) ||
                (cmd.phase == itoa_fmt_pkg::PH_DIG && !(ljust && padn != '0)));
  end

  always_comb begin
    st.div_last = (q == 32'd0) || (nd == itoa_fmt_pkg::ND_W'(itoa_fmt_pkg::NDIG - 1));
    st.empty    = !p_abs && (p_val == '0) && vzero;
    st.cnt_zero = (ph_cnt == '0);
    st.cnt_one  = (cnt == itoa_fmt_pkg::FLD_W'(1));
    st.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag   <= ld_neg ? (32'd0 - in_value) : in_value;
      base  <= ld_base;
      vzero <= ld_vzero;
      lower <= in_lower;
      pfx   <= in_prefix;
      zpad  <= in_zpad;
      ljust <= in_ljust;
      w_sat <= (in_width > itoa_fmt_pkg::FLD_W'(itoa_fmt_pkg::MAX_FIELD)) ?
               itoa_fmt_pkg::FLD_W'(itoa_fmt_pkg::MAX_FIELD) : in_width;
      p_abs <= in_prec[6];
      p_val <= (in_prec[5:0] > itoa_fmt_pkg::FLD_W'(itoa_fmt_pkg::MAX_FIELD)) ?
               itoa_fmt_pkg::FLD_W'(itoa_fmt_pkg::MAX_FIELD) : in_prec[5:0];
      nd    <= '0;
      lead1 <= in_lower ? itoa_fmt_pkg::ASCII_X_LO : itoa_fmt_pkg::ASCII_X_UP;
      if (ld_dec && in_signed) begin
        lead0 <= ld_neg ? itoa_fmt_pkg::ASCII_MINUS :
                 (in_plus ? itoa_fmt_pkg::ASCII_PLUS : itoa_fmt_pkg::ASCII_SPACE);
        nl    <= (ld_neg || in_plus || in_space) ? 2'd1 : 2'd0;
      end else begin
        lead0 <= itoa_fmt_pkg::ASCII_0;
        nl    <= (in_prefix && !ld_vzero && ld_hex) ? 2'd2 : 2'd0;
      end
    end
    if (cmd.step) begin
      dig[nd] <= r;
      nd      <= nd + itoa_fmt_pkg::ND_W'(1);
      mag     <= q;
    end
    if (cmd.calc) begin
      if (!ljust && zpad && p_abs) begin
        zeros <= zeros0 + padn0;
        padn  <= '0;
      end else begin
        zeros <= zeros0;
        padn  <= padn0;
      end
    end
    if (cmd.ph_load) begin
      cnt <= ph_cnt;
    end else if (cmd.emit) begin
      cnt <= cnt - itoa_fmt_pkg::FLD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= ch_sel;
      m_tlast <= last_sel;
    end
  end

  `ITOA_ASSERT(a_emit_slot_free, clk, rst, cmd.emit |-> (!m_tvalid || m_tready))
  `ITOA_ASSERT(a_digit_room, clk, rst, cmd.step |-> (nd < itoa_fmt_pkg::ND_W'(itoa_fmt_pkg::NDIG)))
  `ITOA_ASSERT(a_digit_index, clk, rst, (cmd.emit && cmd.phase == itoa_fmt_pkg::PH_DIG) |-> (cnt != '0 && cnt <= nd_ext))
  `ITOA_ASSERT_NEXT(a_emit_shows, clk, rst, cmd.emit, m_tvalid)

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// Formats one 32-bit integer per input transfer as printf-style ASCII text and streams the
// characters out one per output transfer, with tlast on the final character; a zero value
// with precision zero produces no output at all. An item is accepted, then the digit
// extractor produces one digit per cycle (1 to 11 digits), a layout step sizes the fields,
// and each of the five field sections (left pad, sign/prefix, zeros, digits, right pad) is
// loaded in turn and emits its characters one per cycle through the single output register
// while it is free, held off by any backpressure. The next item is taken once the last
// character of the current one has been loaded into the output register.
module integer_to_ascii_formatter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // value[31:0], base_select[33:32], signed_mode[34], lower_case[35], show_plus[36],
  // space_sign[37], prefix[38], zero_pad[39], left_justify[40], width[46:41],
  // precision[53:47], unused[55:54]
  input  logic [itoa_fmt_pkg::IN_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // ch[7:0]
  output logic [7:0]                    m_tdata,
  output logic                          m_tlast
);

  itoa_fmt_pkg::cmd_t  cmd;
  itoa_fmt_pkg::stat_t st;

  itoa_fmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  itoa_fmt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
